### design/huffman_byte_encoder_packer_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman byte encoder and packer
// Clocked assertion helpers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BYTE_ENCODER_PACKER_TOP_DEFINES_SVH
`define HUFFMAN_BYTE_ENCODER_PACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every rising edge outside reset.
`define HBEP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// Condition that must never be true outside reset.
`define HBEP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define HBEP_ASSERT(lbl, clk, rst_n, prop)
`define HBEP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### design/hbep_pkg.sv
// ----------------------------------------------------------------------------
// Huffman byte encoder package
// Widths, command codes and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package hbep_pkg;

  localparam int unsigned SYM_W            = 8;
  localparam int unsigned CODE_W           = 32;
  localparam int unsigned LEN_W            = 6;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned PEND_W           = 7;
  localparam int unsigned FILL_W           = 3;
  localparam int unsigned NBYTE_W          = 3;
  localparam int unsigned ACC_W            = CODE_W + PEND_W;
  localparam int unsigned TABLE_DEPTH      = 256;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;
  localparam int unsigned IN_TDATA_W       = 48;
  localparam int unsigned OUT_TDATA_W      = 16;

  // Command carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  // Item after the table read.
  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [LEN_W-1:0]  len;   // zero when the symbol adds nothing
    logic [CODE_W-1:0] code;
  } lookup_t;

  // Group of output bytes handed to the emitter, first byte in the top bits.
  typedef struct packed {
    logic               valid;
    logic [CODE_W-1:0]  word;
    logic [NBYTE_W-1:0] nbytes;
    logic               bvalid;
    logic [FILL_W-1:0]  fill;
  } packet_t;

endpackage

### design/huffman_byte_encoder_packer_top.sv
// Path: a request passes the table read register, then the emitter packet
// register, then the output register, where its first result shows. An encode
// gives up to four result bytes and a flush one; they leave one per cycle
// while the output is not stalled. The limit is the single byte-wide output
// register fed from the packet buffer. Reset: synchronous, clears the length
// valid bits and pending bits; there is no clearing pass.
// ----------------------------------------------------------------------------
// Huffman byte encoder and packer, top level
// Table lookup, bit packing and byte emission on streaming channels.
// ----------------------------------------------------------------------------
module huffman_byte_encoder_packer_top #(
  parameter int unsigned MAX_CODE_LEN = hbep_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // symbol [7:0], code_value [39:8], code_length [45:40], zeros [47:46]
  input  logic [hbep_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd [1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_byte [7:0], fill_bits [10:8], zeros [15:11]
  output logic [hbep_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // byte_valid [0]
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast
);
  import hbep_pkg::*;

  lookup_t           lk;
  logic              lk_ready;
  packet_t           pk;
  logic              pk_ready;
  logic [BYTE_W-1:0] o_byte;
  logic              o_bvalid;
  logic [FILL_W-1:0] o_fill;

  // Table lookup and load.
  hbep_table #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_cmd   (cmd_t'(in_tuser)),
    .req_sym   (in_tdata[SYM_W-1:0]),
    .req_code  (in_tdata[SYM_W+CODE_W-1:SYM_W]),
    .req_len   (in_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W]),
    .req_ready (in_tready),
    .lk        (lk),
    .lk_ready  (lk_ready)
  );

  // Bit packing.
  hbep_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .lk       (lk),
    .lk_ready (lk_ready),
    .pk       (pk),
    .pk_ready (pk_ready)
  );

  // Byte emission.
  hbep_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .pk         (pk),
    .pk_ready   (pk_ready),
    .out_valid  (out_tvalid),
    .out_byte   (o_byte),
    .out_bvalid (o_bvalid),
    .out_fill   (o_fill),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

  assign out_tdata = {5'd0, o_fill, o_byte};
  assign out_tuser = o_bvalid;

endmodule

### design/hbep_table.sv
// ----------------------------------------------------------------------------
// Code table
// Holds code and length per symbol in one memory with a registered read.
// Length entries carry valid bits so an unwritten entry reads as no code.
// ----------------------------------------------------------------------------
module hbep_table #(
  parameter int unsigned MAX_CODE_LEN = hbep_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  input  hbep_pkg::cmd_t                req_cmd,
  input  logic [hbep_pkg::SYM_W-1:0]    req_sym,
  input  logic [hbep_pkg::CODE_W-1:0]   req_code,
  input  logic [hbep_pkg::LEN_W-1:0]    req_len,
  output logic                          req_ready,
  output hbep_pkg::lookup_t             lk,
  input  logic                          lk_ready
);
  import hbep_pkg::*;

  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int unsigned ENTRY_W = LEN_W + CODE_W;

  logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [ENTRY_W-1:0]     rd_r;
  logic                   rd_vld_r;
  logic                   sym_zero_r;
  logic                   s1_valid_r;
  cmd_t                   s1_cmd_r;
  logic                   accept;
  logic [LEN_W-1:0]       len_sat;

  assign req_ready = !s1_valid_r || lk_ready;
  assign accept    = req_valid && req_ready;

  // Saturate a loaded length to the supported maximum.
  assign len_sat = (req_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req_len;

  // Table memory: load writes, every request reads.
  always_ff @(posedge clk) begin
    if (accept && req_cmd == CMD_LOAD) begin
      mem[req_sym] <= {len_sat, req_code};
    end
    if (accept) begin
      rd_r       <= mem[req_sym];
      sym_zero_r <= (req_sym == '0);
      s1_cmd_r   <= req_cmd;
    end
  end

  // Valid bits and the stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_vld_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_r <= vld_r[req_sym];
      end
      if (accept && req_cmd == CMD_LOAD) begin
        vld_r[req_sym] <= 1'b1;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (lk_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Byte zero and unwritten entries contribute no bits.
  always_comb begin
    lk.valid = s1_valid_r;
    lk.cmd   = s1_cmd_r;
    lk.len   = (sym_zero_r || !rd_vld_r) ? '0 : rd_r[ENTRY_W-1 -: LEN_W];
    lk.code  = rd_r[CODE_W-1:0];
  end

endmodule

### design/hbep_packer.sv
// ----------------------------------------------------------------------------
// Bit packer
// Appends codes to the pending bits and splits off the complete bytes.
// A flush turns the pending bits into one right-aligned final byte.
// ----------------------------------------------------------------------------
module hbep_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  hbep_pkg::lookup_t lk,
  output logic              lk_ready,
  output hbep_pkg::packet_t pk,
  input  logic              pk_ready
);
  import hbep_pkg::*;

  logic [PEND_W-1:0]  pend_bits_r, pend_bits_nxt;
  logic [FILL_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [CODE_W:0]    mask;
  logic [CODE_W-1:0]  code_m;
  logic [ACC_W-1:0]   acc;
  logic [LEN_W-1:0]   count;
  logic [NBYTE_W-1:0] nbytes;
  logic [FILL_W-1:0]  rem;
  logic [CODE_W-1:0]  emit;
  logic [LEN_W-1:0]   lshift;
  logic               is_enc;
  logic               is_flush;
  logic               has_pkt;
  logic               fire;

  // Append the code below the pending bits.
  always_comb begin
    mask   = (CODE_W+1)'(((CODE_W+1)'(1) << lk.len) - (CODE_W+1)'(1));
    code_m = lk.code & mask[CODE_W-1:0];
    acc    = (ACC_W'(pend_bits_r) << lk.len) | ACC_W'(code_m);
    count  = LEN_W'(pend_cnt_r) + lk.len;
    nbytes = count[LEN_W-1:FILL_W];
    rem    = count[FILL_W-1:0];
    emit   = CODE_W'(acc >> rem);
    lshift = {3'(3'd4 - nbytes), 3'b000};
  end

  assign is_enc   = lk.valid && lk.cmd == CMD_ENCODE && lk.len != '0;
  assign is_flush = lk.valid && lk.cmd == CMD_FLUSH;
  assign has_pkt  = is_flush || (is_enc && nbytes != '0);
  assign fire     = lk.valid && (!has_pkt || pk_ready);
  assign lk_ready = !lk.valid || fire;

  // Packet toward the emitter.
  always_comb begin
    pk.valid = has_pkt;
    if (is_flush) begin
      pk.word   = {1'b0, pend_bits_r, 24'd0};
      pk.nbytes = NBYTE_W'(1);
      pk.bvalid = (pend_cnt_r != '0);
      pk.fill   = FILL_W'(-pend_cnt_r);
    end else begin
      pk.word   = emit << lshift;
      pk.nbytes = nbytes;
      pk.bvalid = 1'b1;
      pk.fill   = '0;
    end
  end

  // Next pending state.
  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (fire && is_flush) begin
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
    end else if (fire && is_enc) begin
      pend_bits_nxt = acc[PEND_W-1:0] & PEND_W'((8'd1 << rem) - 8'd1);
      pend_cnt_nxt  = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

### design/hbep_emitter.sv
// ----------------------------------------------------------------------------
// Byte emitter
// Holds one packet and moves its bytes into the output register, one per cycle
// while the output is not stalled. A packet's last byte has the last flag.
// ----------------------------------------------------------------------------
`include "huffman_byte_encoder_packer_top_defines.svh"

module hbep_emitter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hbep_pkg::packet_t            pk,
  output logic                         pk_ready,
  output logic                         out_valid,
  output logic [hbep_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_bvalid,
  output logic [hbep_pkg::FILL_W-1:0]  out_fill,
  output logic                         out_last,
  input  logic                         out_ready
);
  import hbep_pkg::*;

  logic               pk_valid_r;
  logic [CODE_W-1:0]  word_r;
  logic [NBYTE_W-1:0] nleft_r;
  logic               bvalid_r;
  logic [FILL_W-1:0]  fill_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_bvalid_r;
  logic [FILL_W-1:0]  out_fill_r;
  logic               out_last_r;
  logic               mv;
  logic               last_byte;

  assign last_byte = (nleft_r == NBYTE_W'(1));
  assign mv        = pk_valid_r && (!out_valid_r || out_ready);
  assign pk_ready  = !pk_valid_r || (mv && last_byte);

  // Packet holding register and output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pk_ready && pk.valid) begin
        pk_valid_r <= 1'b1;
      end else if (mv && last_byte) begin
        pk_valid_r <= 1'b0;
      end
      if (mv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pk_ready && pk.valid) begin
      word_r   <= pk.word;
      nleft_r  <= pk.nbytes;
      bvalid_r <= pk.bvalid;
      fill_r   <= pk.fill;
    end else if (mv) begin
      word_r  <= word_r << BYTE_W;
      nleft_r <= nleft_r - NBYTE_W'(1);
    end
    if (mv) begin
      out_byte_r   <= word_r[CODE_W-1 -: BYTE_W];
      out_bvalid_r <= bvalid_r;
      out_fill_r   <= fill_r;
      out_last_r   <= last_byte;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_bvalid = out_bvalid_r;
  assign out_fill   = out_fill_r;
  assign out_last   = out_last_r;

  // A held packet always has between one and four bytes left.
  `HBEP_ASSERT(a_nleft_range, clk, rst_n,
    !pk_valid_r || (nleft_r != '0 && nleft_r <= NBYTE_W'(4)))
  // An empty flush result closes its request and has no padding.
  `HBEP_ASSERT(a_empty_flush, clk, rst_n,
    !(out_valid_r && !out_bvalid_r) || (out_last_r && out_fill_r == '0))
  // Padding only appears on a final byte.
  `HBEP_ASSERT_NEVER(a_fill_not_last, clk, rst_n,
    out_valid_r && out_fill_r != '0 && !out_last_r)
  // A packet is taken only when the previous one has drained.
  `HBEP_ASSERT(a_no_overwrite, clk, rst_n,
    !(pk_valid_r && !(mv && last_byte)) || !pk_ready)

endmodule

### tb/huffman_byte_encoder_packer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman byte encoder and packer testbench
// Loads code table entries, encodes byte streams and flushes the bit store
// while both stream channels idle at random. A scoreboard keeps its own copy
// of the code table and pending bits, predicts every output byte and checks
// each one as it leaves the block.
// ----------------------------------------------------------------------------

// One output byte as seen on the result channel.
typedef struct packed {
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [2:0] fill_bits;
  logic       last;
} out_beat_t;

// Scoreboard: predicts packed bytes per accepted request and checks results.
class hbep_scoreboard;
  logic [31:0] code_tbl [256];
  logic [5:0]  len_tbl [256];
  logic [6:0]  pend_bits;
  int          pend_cnt;
  out_beat_t   awaited_bytes [$];
  int          mismatches;

  function new();
    foreach (len_tbl[i]) len_tbl[i] = '0;
    pend_bits  = '0;
    pend_cnt   = 0;
    mismatches = 0;
  endfunction

  // Update the table or bit store and queue the bytes this request yields.
  function void note_request(logic [1:0] cmd, logic [7:0] sym, logic [31:0] cval,
                             logic [5:0] clen);
    logic [38:0] acc;
    int          len;
    int          count;
    int          produced;
    out_beat_t   beat;
    case (cmd)
      hbep_pkg::CMD_LOAD: begin
        code_tbl[sym] = cval;
        len_tbl[sym]  = (clen > hbep_pkg::MAX_CODE_LEN_DEF) ?
                        6'(hbep_pkg::MAX_CODE_LEN_DEF) : clen;
      end
      hbep_pkg::CMD_ENCODE: begin
        // Byte zero and symbols without a code leave everything untouched.
        if (sym != 8'd0 && len_tbl[sym] != 6'd0) begin
          len      = int'(len_tbl[sym]);
          acc      = ({32'd0, pend_bits} << len) |
                     ({7'd0, code_tbl[sym]} & ((39'd1 << len) - 39'd1));
          count    = pend_cnt + len;
          produced = 0;
          while (count >= 8) begin
            count          -= 8;
            beat.data_byte  = acc[count +: 8];
            beat.byte_valid = 1'b1;
            beat.fill_bits  = 3'd0;
            beat.last       = 1'b0;
            awaited_bytes   = {awaited_bytes, beat};
            produced++;
          end
          pend_bits = 7'(acc & ((39'd1 << count) - 39'd1));
          pend_cnt  = count;
          if (produced > 0) awaited_bytes[awaited_bytes.size() - 1].last = 1'b1;
        end
      end
      hbep_pkg::CMD_FLUSH: begin
        // Leftover bits go out right-aligned; an empty store gives a null byte.
        beat.data_byte  = {1'b0, pend_bits};
        beat.byte_valid = (pend_cnt != 0);
        beat.fill_bits  = (pend_cnt != 0) ? 3'(8 - pend_cnt) : 3'd0;
        beat.last       = 1'b1;
        awaited_bytes   = {awaited_bytes, beat};
        pend_bits = '0;
        pend_cnt  = 0;
      end
      default: ;
    endcase
  endfunction

  // Compare one output byte with the oldest prediction.
  function void check_result(out_beat_t got);
    out_beat_t exp;
    if (awaited_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected byte %h valid %b fill %0d last %b", $time,
                 got.data_byte, got.byte_valid, got.fill_bits, got.last);
      return;
    end
    exp = awaited_bytes.pop_front();
    if (got.data_byte !== exp.data_byte || got.byte_valid !== exp.byte_valid ||
        got.fill_bits !== exp.fill_bits || got.last !== exp.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: byte %h/%h valid %b/%b fill %0d/%0d last %b/%b (expected/actual)",
                 $time, exp.data_byte, got.data_byte, exp.byte_valid, got.byte_valid,
                 exp.fill_bits, got.fill_bits, exp.last, got.last);
    end
  endfunction
endclass

module huffman_byte_encoder_packer_top_test;
  import hbep_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;

  hbep_scoreboard sb = new();

  int idle_pct  = 0;
  int stall_pct = 0;
  bit loaded [256];
  logic [7:0] loaded_syms [$];

  huffman_byte_encoder_packer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, and every accepted byte goes to the scoreboard.
  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{out_tdata[7:0], out_tuser[0], out_tdata[10:8], out_tlast});
  end

  // Offer one request after a random idle gap and wait until it is taken.
  task automatic send_request(logic [1:0] cmd, logic [7:0] sym, logic [31:0] cval,
                              logic [5:0] clen);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, clen, cval, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(cmd, sym, cval, clen);
    if (cmd == CMD_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms = {loaded_syms, sym};
    end
  endtask

  // Hold off until every predicted byte has come out, then let the pipe settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.awaited_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly table loads and encodes of loaded symbols, with flushes and noise.
  task automatic random_request(output bit counted);
    int          pick;
    int          len_kind;
    logic [7:0]  sym;
    logic [31:0] cval;
    logic [5:0]  clen;
    pick    = $urandom_range(99);
    sym     = 8'($urandom_range(255));
    cval    = $urandom();
    clen    = 6'($urandom_range(63));
    counted = 1'b1;
    if (pick < 15 || loaded_syms.size() == 0) begin
      len_kind = $urandom_range(9);
      if (len_kind == 0)      clen = 6'd0;
      else if (len_kind == 1) clen = 6'($urandom_range(63, 33));
      else if (len_kind == 2) clen = 6'($urandom_range(32, 13));
      else                    clen = 6'($urandom_range(12, 1));
      send_request(CMD_LOAD, sym, cval, clen);
    end else if (pick < 82) begin
      sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
      send_request(CMD_ENCODE, sym, cval, clen);
    end else if (pick < 96) begin
      send_request(CMD_FLUSH, sym, cval, clen);
    end else begin
      send_request(CMD_UNUSED, sym, cval, clen);
      counted = 1'b0;
    end
  endtask

  // Main sequence: reset, directed cases, then random phases of idling.
  initial begin
    int phase;
    int done_items;
    bit counted;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty flush straight after reset.
    send_request(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // Table: byte zero, full-width codes, oversized lengths, a missing code.
    send_request(CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd8);
    send_request(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_request(CMD_LOAD, 8'h01, 32'h0000_0000, 6'd1);
    send_request(CMD_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd63);
    send_request(CMD_LOAD, 8'h55, 32'h1234_5678, 6'd0);
    send_request(CMD_LOAD, 8'h2A, 32'h0000_0005, 6'd3);
    send_request(CMD_LOAD, 8'h7F, 32'h0000_0001, 6'd33);
    // Skipped symbols, then a four-byte code on top of one pending bit.
    send_request(CMD_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'h55, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'h2A, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'h80, 32'h0, 6'd0);
    send_request(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
    // Seven pending bits plus a 32-bit code: the widest accumulation.
    send_request(CMD_ENCODE, 8'h2A, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'h2A, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(CMD_ENCODE, 8'h7F, 32'h0, 6'd0);
    send_request(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(CMD_LOAD, 8'h55, 32'h0000_001F, 6'd5);
    send_request(CMD_ENCODE, 8'h55, 32'h0, 6'd0);
    send_request(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both light.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      done_items = 0;
      while (done_items < 75) begin
        random_request(counted);
        if (counted) done_items++;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASS huffman_byte_encoder_packer_top");
    else
      $display("FAIL huffman_byte_encoder_packer_top");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("FAIL huffman_byte_encoder_packer_top");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/hbep_pkg.sv
design/hbep_table.sv
design/hbep_packer.sv
design/hbep_emitter.sv
design/huffman_byte_encoder_packer_top.sv
tb/huffman_byte_encoder_packer_top_test.sv
